>>> hdl/itp_pkg.sv
package itp_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int PTR_W = $clog2(STACK_DEPTH);

   localparam logic [7:0] CHAR_POW    = 8'h5E;
   localparam logic [7:0] CHAR_MUL    = 8'h2A;
   localparam logic [7:0] CHAR_DIV    = 8'h2F;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_UNDER  = 8'h5F;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_NUL    = 8'h00;

   typedef enum logic [2:0] {
      OP_LPAREN = 3'd0,
      OP_PLUS   = 3'd1,
      OP_MINUS  = 3'd2,
      OP_MUL    = 3'd3,
      OP_DIV    = 3'd4,
      OP_POW    = 3'd5
   } op_code_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_START,
      S_WORK,
      S_SPACE
   } state_type;

   typedef enum logic [1:0] {
      EMIT_CHAR,
      EMIT_OP,
      EMIT_SPACE,
      EMIT_TERM
   } emit_sel_type;

   typedef struct packed {
      logic         load;
      logic         emit;
      emit_sel_type emit_sel;
      logic         last;
      logic         push;
      logic         pop;
      logic         set_in_name;
      logic         clr_in_name;
      logic         clr_end;
   } dp_cmd_type;

   typedef struct packed {
      logic kind_end;
      logic is_name;
      logic is_lparen;
      logic is_rparen;
      logic is_op;
      logic in_name;
      logic stack_empty;
      logic top_lparen;
      logic top_yields;
      logic out_free;
   } dp_status_type;

   function automatic logic is_name_char(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == CHAR_UNDER;
   endfunction

   function automatic logic is_op_char(input logic [7:0] c);
      return c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_MUL ||
             c == CHAR_DIV || c == CHAR_POW;
   endfunction

   function automatic op_code_type char_to_op(input logic [7:0] c);
      op_code_type op;
      unique case (c)
         CHAR_PLUS:  op = OP_PLUS;
         CHAR_MINUS: op = OP_MINUS;
         CHAR_MUL:   op = OP_MUL;
         CHAR_DIV:   op = OP_DIV;
         CHAR_POW:   op = OP_POW;
         default:    op = OP_LPAREN;
      endcase
      return op;
   endfunction

   function automatic logic [7:0] op_to_char(input op_code_type op);
      logic [7:0] c;
      unique case (op)
         OP_LPAREN: c = CHAR_LPAREN;
         OP_PLUS:   c = CHAR_PLUS;
         OP_MINUS:  c = CHAR_MINUS;
         OP_MUL:    c = CHAR_MUL;
         OP_DIV:    c = CHAR_DIV;
         OP_POW:    c = CHAR_POW;
         default:   c = CHAR_NUL;
      endcase
      return c;
   endfunction

   function automatic logic [1:0] op_prec(input op_code_type op);
      logic [1:0] p;
      unique case (op)
         OP_PLUS, OP_MINUS: p = 2'd1;
         OP_MUL, OP_DIV:    p = 2'd2;
         OP_POW:            p = 2'd3;
         default:           p = 2'd0;
      endcase
      return p;
   endfunction

endpackage

>>> hdl/infix_to_postfix_converter_core.sv
// Infix to postfix converter (shunting-yard), one character per item.
// Input channel req_*: req_kind 0 carries an expression character in
// req_char_in, req_kind 1 ends the expression and flushes the stack.
// Result channel rsp_*: postfix characters (name characters, operators,
// separating spaces), then one terminating item with rsp_end_of_expr set,
// rsp_out_char zero and rsp_overflow telling whether a push was dropped.
// rsp_last marks the final result caused by each input item; an input
// item may cause none.
// Timing: an item is taken in one cycle and decoded in the next. A popped
// operator is emitted as the operator, then a space; a '(' dropped at
// flush is a step of its own, as is the space that closes a name. One
// item is worked on at a time. The first result of an item passes through
// the output register before it shows on rsp_valid.
// A single output register holds the next result; req_ready comes back
// while it still waits, and a stalled receiver holds the controller in
// place wherever it has a result to emit, until the register frees up.
// Reset (synchronous, active high) empties the stack and clears the name
// and overflow flags and the output register's valid flag.
module infix_to_postfix_converter_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_end_of_expr,
   output logic       rsp_overflow,
   output logic       rsp_last
);
   import itp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing: accept, name space, pops, push
   itp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // stack, flags and output register
   itp_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_kind        (req_kind),
      .req_char_in     (req_char_in),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_char    (rsp_out_char),
      .rsp_end_of_expr (rsp_end_of_expr),
      .rsp_overflow    (rsp_overflow),
      .rsp_last        (rsp_last)
   );

endmodule

>>> hdl/itp_datapath.sv
module itp_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_kind,
   input  logic [7:0]              req_char_in,
   input  itp_pkg::dp_cmd_type     cmd,
   output itp_pkg::dp_status_type  status,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [7:0]              rsp_out_char,
   output logic                    rsp_end_of_expr,
   output logic                    rsp_overflow,
   output logic                    rsp_last
);
   import itp_pkg::*;

   // latched input item
   logic        kind_ff;
   logic [7:0]  char_ff;

   // operator stack
   op_code_type stack_mem [STACK_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic        in_name_ff, in_name_in;
   logic        ovf_seen_ff, ovf_seen_in;

   // output register
   logic        valid_ff, valid_in;
   logic [7:0]  ochar_ff, ochar_in;
   logic        oend_ff, oend_in;
   logic        oovf_ff, oovf_in;
   logic        olast_ff, olast_in;

   logic [PTR_W-1:0] top_idx;
   op_code_type top_op, cur_op, push_op;
   logic        full;
   logic [1:0]  pt, pc;

   assign top_idx = PTR_W'(count_ff - CNT_W'(1));
   assign top_op  = stack_mem[top_idx];
   assign cur_op  = char_to_op(char_ff);
   assign full    = (count_ff == CNT_W'(STACK_DEPTH));
   assign pt      = op_prec(top_op);
   assign pc      = op_prec(cur_op);
   assign push_op = (char_ff == CHAR_LPAREN) ? OP_LPAREN : cur_op;

   always_comb begin
      status.kind_end    = kind_ff;
      status.is_name     = !kind_ff && is_name_char(char_ff);
      status.is_lparen   = !kind_ff && char_ff == CHAR_LPAREN;
      status.is_rparen   = !kind_ff && char_ff == CHAR_RPAREN;
      status.is_op       = !kind_ff && is_op_char(char_ff);
      status.in_name     = in_name_ff;
      status.stack_empty = (count_ff == '0);
      status.top_lparen  = (top_op == OP_LPAREN);
      // ^ is right-associative: equal precedence pops only for left ops
      status.top_yields  = (pt > pc) || (pt == pc && cur_op != OP_POW);
      status.out_free    = !valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         char_ff <= req_char_in;
      end
      if (cmd.push && !full) begin
         stack_mem[count_ff[PTR_W-1:0]] <= push_op;
      end
   end

   always_comb begin
      count_in    = count_ff;
      in_name_in  = in_name_ff;
      ovf_seen_in = ovf_seen_ff;
      if (cmd.push) begin
         if (full) begin
            ovf_seen_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.set_in_name) begin
         in_name_in = 1'b1;
      end
      if (cmd.clr_in_name) begin
         in_name_in = 1'b0;
      end
      if (cmd.clr_end) begin
         count_in    = '0;
         in_name_in  = 1'b0;
         ovf_seen_in = 1'b0;
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      ochar_in = ochar_ff;
      oend_in  = oend_ff;
      oovf_in  = oovf_ff;
      olast_in = olast_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         oend_in  = 1'b0;
         oovf_in  = 1'b0;
         olast_in = cmd.last;
         unique case (cmd.emit_sel)
            EMIT_CHAR:  ochar_in = char_ff;
            EMIT_OP:    ochar_in = op_to_char(top_op);
            EMIT_SPACE: ochar_in = CHAR_SPACE;
            EMIT_TERM: begin
               ochar_in = CHAR_NUL;
               oend_in  = 1'b1;
               oovf_in  = ovf_seen_ff;
            end
            default:    ochar_in = CHAR_NUL;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         in_name_ff  <= 1'b0;
         ovf_seen_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         count_ff    <= count_in;
         in_name_ff  <= in_name_in;
         ovf_seen_ff <= ovf_seen_in;
         valid_ff    <= valid_in;
      end
      ochar_ff <= ochar_in;
      oend_ff  <= oend_in;
      oovf_ff  <= oovf_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_char    = ochar_ff;
   assign rsp_end_of_expr = oend_ff;
   assign rsp_overflow    = oovf_ff;
   assign rsp_last        = olast_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!valid_ff || rsp_ready))
      else $error("emit into an occupied output register");

   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && full && !cmd.clr_end) |=> ovf_seen_ff)
      else $error("dropped push did not set overflow");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && oend_ff) |-> olast_ff)
      else $error("terminating item not marked last");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (count_ff != '0))
      else $error("pop of empty stack");
`endif

endmodule

>>> hdl/itp_controller.sv
module itp_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  itp_pkg::dp_status_type  status,
   output itp_pkg::dp_cmd_type     cmd
);
   import itp_pkg::*;

   state_type  state_ff, state_in;
   dp_cmd_type work_cmd;
   state_type  work_next;
   logic       pop_op;
   logic       more;

   // an operator leaves the stack for this item
   assign pop_op = !status.stack_empty && !status.top_lparen &&
                   (status.is_rparen || (status.is_op && status.top_yields));
   // another result follows the current one for this item
   assign more = status.kind_end || pop_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // one step of stack work for the latched item
   always_comb begin
      work_cmd  = '0;
      work_next = S_IDLE;
      if (status.kind_end) begin
         if (status.stack_empty) begin
            if (status.out_free) begin
               work_cmd.emit     = 1'b1;
               work_cmd.emit_sel = EMIT_TERM;
               work_cmd.last     = 1'b1;
               work_cmd.clr_end  = 1'b1;
               work_next         = S_IDLE;
            end else begin
               work_next = S_WORK;
            end
         end else if (status.top_lparen) begin
            work_cmd.pop = 1'b1;
            work_next    = S_WORK;
         end else if (status.out_free) begin
            work_cmd.emit     = 1'b1;
            work_cmd.emit_sel = EMIT_OP;
            work_cmd.pop      = 1'b1;
            work_next         = S_SPACE;
         end else begin
            work_next = S_WORK;
         end
      end else if (pop_op) begin
         if (status.out_free) begin
            work_cmd.emit     = 1'b1;
            work_cmd.emit_sel = EMIT_OP;
            work_cmd.pop      = 1'b1;
            work_next         = S_SPACE;
         end else begin
            work_next = S_WORK;
         end
      end else if (status.is_rparen) begin
         // matching '(' is dropped; unmatched ')' does nothing
         work_cmd.pop = !status.stack_empty;
      end else if (status.is_op || status.is_lparen) begin
         work_cmd.push = 1'b1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            if (status.is_name) begin
               if (status.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_sel    = EMIT_CHAR;
                  cmd.last        = 1'b1;
                  cmd.set_in_name = 1'b1;
                  state_in        = S_IDLE;
               end
            end else if (status.in_name) begin
               if (status.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_sel    = EMIT_SPACE;
                  cmd.last        = !more;
                  cmd.clr_in_name = 1'b1;
                  state_in        = S_WORK;
               end
            end else begin
               cmd      = work_cmd;
               state_in = work_next;
            end
         end
         S_WORK: begin
            cmd      = work_cmd;
            state_in = work_next;
         end
         S_SPACE: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_SPACE;
               cmd.last     = !more;
               state_in     = S_WORK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
